@@ rtl/i2st_pkg.sv @@
// Package for the I2S slave bit transceiver: default parameters, beat layout.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package i2st_pkg;

  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int SLOT_BITS_DEF    = 32;
  localparam int BLOCK_FRAMES_DEF = 64;

  localparam int TX_W   = 24;
  localparam int SLOT_W = 7;
  localparam int CNT_W  = 6;
  localparam int BI_W   = 7;

  // input beat
  localparam int IN_LRCK  = 0;
  localparam int IN_DIN   = 1;
  localparam int IN_TX_LO = 2;
  localparam int IN_W     = 32;

  // output beat
  localparam int OUT_DOUT    = 0;
  localparam int OUT_VALID   = 1;
  localparam int OUT_SMP_LO  = 2;
  localparam int OUT_SLOT_LO = OUT_SMP_LO + TX_W;
  localparam int OUT_BANK    = OUT_SLOT_LO + SLOT_W;
  localparam int OUT_DONE    = OUT_BANK + 1;
  localparam int OUT_ERR     = OUT_DONE + 1;
  localparam int OUT_W       = 40;

endpackage

`default_nettype wire

@@ rtl/i2s_slave_bit_transceiver.sv @@
// I2S slave bit transceiver, one beat per rising bit clock edge.
// Depends on i2st_pkg.
//
// Usage: each input beat carries the LRCK level and DIN bit sampled at one
// rising bit clock edge plus the next word to transmit. Each beat yields
// exactly one output beat: the DOUT bit to drive after the following falling
// edge, a received word with slot index and bank when one completes, a block
// done flag and a slot length error flag.
// Each output beat is taken from the output register. Throughput: one beat
// per cycle while the receiver takes output beats; the full slot tracking, shift and
// transmit bit select sit between the accepted beat and the output register.
// The input side is ready whenever the output register is empty or is being
// taken in the same cycle, so a stalled receiver holds its beat and stalls
// the input after one beat.
// Reset: the block comes up muted and unsynced, with transfer lag 1 (I2S).
// Received words are given only after the first LRCK change to left.
// cfg_we_i writes the transfer lag bit; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none

module i2s_slave_bit_transceiver #(
  parameter int SAMPLE_BITS  = i2st_pkg::SAMPLE_BITS_DEF,
  parameter int SLOT_BITS    = i2st_pkg::SLOT_BITS_DEF,
  parameter int BLOCK_FRAMES = i2st_pkg::BLOCK_FRAMES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_wdata_i,   // transfer_lag
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // lrck_level[0], din_bit[1], tx_sample[25:2], zero fill
  input  wire logic [i2st_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // dout_bit[0], rx_valid[1], rx_sample[25:2], rx_slot[32:26], rx_bank[33],
  // block_done[34], sync_error[35], zero fill
  output logic [i2st_pkg::OUT_W-1:0]       m_axis_tdata
);

  localparam int BPW = $clog2(2 * BLOCK_FRAMES + 1);
  localparam int TXW = i2st_pkg::TX_W;
  localparam int BIW = i2st_pkg::BI_W;
  localparam int CW  = i2st_pkg::CNT_W;

  localparam logic signed [BIW-1:0] BI_MSB  = BIW'(SAMPLE_BITS - 1);
  localparam logic signed [BIW-1:0] BI_LAG  = BIW'(SAMPLE_BITS - SLOT_BITS);
  localparam logic signed [BIW-1:0] BI_SLOT = BIW'(SLOT_BITS);
  localparam logic signed [BIW-1:0] BI_SAMP = BIW'(SAMPLE_BITS);
  localparam logic [CW-1:0]  CNT_LAST = CW'(SLOT_BITS - 1);
  localparam logic [CW-1:0]  CNT_SLOT = CW'(SLOT_BITS);
  localparam logic [CW-1:0]  CNT_MAX  = '1;
  localparam logic [BPW-1:0] POS_END  = BPW'(2 * BLOCK_FRAMES);

  logic                    lag_q;
  logic                    lrck_q, lrck_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic signed [BIW-1:0]   bi_q, bi_d, bi_cur;
  logic [TXW-1:0]          rx_q, rx_d;
  logic [TXW-1:0]          tx_q, tx_d;
  logic                    await_q, await_d;
  logic [BPW-1:0]          pos_q, pos_d, pos_cur, pos_inc;
  logic                    bank_q, bank_d;

  logic                    m_valid_q;
  logic [i2st_pkg::OUT_W-1:0] m_data_q, m_data_d;

  logic                    lrck, din;
  logic [TXW-1:0]          txs;
  logic                    err, valid, done, dout;
  logic [TXW-1:0]          sample;
  logic [BPW-1:0]          slot;
  logic [BPW+i2st_pkg::SLOT_W-1:0] slot_ext;
  logic                    bank;
  logic [31:0]             tx_ext;
  logic                    acc;

  assign acc           = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign lrck = s_axis_tdata[i2st_pkg::IN_LRCK];
  assign din  = s_axis_tdata[i2st_pkg::IN_DIN];
  assign txs  = s_axis_tdata[i2st_pkg::IN_TX_LO +: TXW];

  always_comb begin
    err     = 1'b0;
    lrck_d  = lrck_q;
    cnt_d   = cnt_q;
    bi_cur  = bi_q;
    await_d = await_q;
    pos_cur = pos_q;
    bank_d  = bank_q;
    rx_d    = rx_q;
    tx_d    = tx_q;
    valid   = 1'b0;
    done    = 1'b0;
    sample  = '0;
    slot    = '0;
    bank    = 1'b0;

    if (lrck != lrck_q) begin
      if (cnt_q != CNT_LAST && !await_q) begin
        err = 1'b1;
      end
      cnt_d  = '0;
      lrck_d = lrck;
      bi_cur = lag_q ? BI_LAG : BI_MSB;
      if (await_q && !lrck) begin
        await_d    = 1'b0;
        pos_cur[0] = lag_q;
      end
    end else begin
      if (cnt_q != CNT_MAX) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (cnt_d >= CNT_SLOT && !await_q) begin
        err = 1'b1;
      end
    end

    if (bi_cur == BI_MSB) begin
      rx_d = {TXW{din}};
    end else if (bi_cur >= 0 && bi_cur < BI_MSB) begin
      rx_d = {rx_q[TXW-2:0], din};
    end

    bi_d = bi_cur - BIW'(1);
    if (bi_d < BI_LAG) begin
      bi_d = bi_d + BI_SLOT;
    end

    pos_d   = pos_cur;
    pos_inc = pos_cur + 1'b1;
    if (bi_d == BI_MSB && !await_d) begin
      valid  = 1'b1;
      sample = rx_d;
      slot   = pos_cur;
      bank   = bank_q;
      if (pos_inc >= POS_END) begin
        pos_d  = {{(BPW-1){1'b0}}, lag_q ? lrck : !lrck};
        bank_d = !bank_q;
        done   = 1'b1;
      end else begin
        pos_d = pos_inc;
      end
      tx_d = txs;
    end

    tx_ext = {{(32-TXW){tx_d[TXW-1]}}, tx_d};
    dout   = 1'b0;
    if (bi_d >= 0 && bi_d < BI_SAMP) begin
      dout = tx_ext[bi_d[4:0]];
    end

    slot_ext = {{i2st_pkg::SLOT_W{1'b0}}, slot};
    m_data_d = '0;
    m_data_d[i2st_pkg::OUT_DOUT]                    = dout;
    m_data_d[i2st_pkg::OUT_VALID]                   = valid;
    m_data_d[i2st_pkg::OUT_SMP_LO +: TXW]           = sample;
    m_data_d[i2st_pkg::OUT_SLOT_LO +: i2st_pkg::SLOT_W] = slot_ext[i2st_pkg::SLOT_W-1:0];
    m_data_d[i2st_pkg::OUT_BANK]                    = bank;
    m_data_d[i2st_pkg::OUT_DONE]                    = done;
    m_data_d[i2st_pkg::OUT_ERR]                     = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q   <= 1'b1;
      lrck_q  <= 1'b0;
      cnt_q   <= '0;
      bi_q    <= '1;
      rx_q    <= '0;
      tx_q    <= '0;
      await_q <= 1'b1;
      pos_q   <= '0;
      bank_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lag_q <= cfg_wdata_i;
      end
      if (acc) begin
        lrck_q  <= lrck_d;
        cnt_q   <= cnt_d;
        bi_q    <= bi_d;
        rx_q    <= rx_d;
        tx_q    <= tx_d;
        await_q <= await_d;
        pos_q   <= pos_d;
        bank_q  <= bank_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (acc) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/i2st_checker.sv @@
// Port-level checks for the I2S slave bit transceiver, bound to the top level.
// Depends on i2st_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2st_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [i2st_pkg::OUT_W-1:0] m_axis_tdata
);

  logic valid_w, done_w;
  assign valid_w = m_axis_tdata[i2st_pkg::OUT_VALID];
  assign done_w  = m_axis_tdata[i2st_pkg::OUT_DONE];

  // no word: payload fields read zero
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !valid_w |->
      m_axis_tdata[i2st_pkg::OUT_DONE:i2st_pkg::OUT_SMP_LO] == '0)
    else $error("fields set on a beat without a received word");

  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && done_w |-> valid_w)
    else $error("block done without a received word");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat gave no output beat");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

endmodule

bind i2s_slave_bit_transceiver i2st_checker u_i2st_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
